>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OBTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/obts_pkg.sv
// ----------------------------------------------------------------------------
// obts_pkg
// Shared types, constants and helpers for the ordered bitmap tree set.
// ----------------------------------------------------------------------------
`default_nettype none

package obts_pkg;

	localparam int CMD_W   = 3;
	localparam int KEY_W   = 18;
	localparam int CNT_W   = 19;
	localparam int DIG_W   = 6;
	localparam int WORD_W  = 64;
	localparam int LEAF_AW = 12;
	localparam int MID_AW  = 6;
	localparam int LEAF_DEPTH = 4096;
	localparam int MID_DEPTH  = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_ERASE  = 3'd1,
		CMD_MEMBER = 3'd2,
		CMD_MIN    = 3'd3,
		CMD_MAX    = 3'd4,
		CMD_SUCC   = 3'd5,
		CMD_PRED   = 3'd6,
		CMD_UNUSED = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_DMID_W,
		S_DLEAF_W,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_DMID,
		ACT_DLEAF
	} act_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic dmid;
		logic dleaf;
		logic push;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		act_t act;
	} ctl_sts_t;

	// Position of the lowest or highest set bit; zero for an empty word.
	function automatic logic [DIG_W-1:0] find_bit(input logic [WORD_W-1:0] w,
			input logic lowest);
		logic [DIG_W-1:0] r;
		r = '0;
		if (lowest) begin
			for (int i = WORD_W - 1; i >= 0; i--)
				if (w[i]) r = DIG_W'(i);
		end else begin
			for (int i = 0; i < WORD_W; i++)
				if (w[i]) r = DIG_W'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/obts_ram.sv
// ----------------------------------------------------------------------------
// obts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module obts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/obts_ctrl.sv
// ----------------------------------------------------------------------------
// obts_ctrl
// Sequencer: clearing pass, item evaluation, tree descent, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module obts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire obts_pkg::ctl_sts_t sts,
	output obts_pkg::ctl_cmd_t     cmd
);
	import obts_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				unique case (sts.act)
					ACT_DMID:  state_d = S_DMID_W;
					ACT_DLEAF: state_d = S_DLEAF_W;
					default:   state_d = S_DONE;
				endcase
			end
			S_DMID_W: begin
				cmd.dmid = 1'b1;
				state_d  = S_DLEAF_W;
			end
			S_DLEAF_W: begin
				cmd.dleaf = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/obts_dpath.sv
// ----------------------------------------------------------------------------
// obts_dpath
// Datapath: word memories, root word, count, masks and bit search.
// ----------------------------------------------------------------------------
`default_nettype none

module obts_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire obts_pkg::ctl_cmd_t            cmd,
	output obts_pkg::ctl_sts_t                 sts,
	input  wire logic [obts_pkg::CMD_W-1:0]    in_command,
	input  wire logic [obts_pkg::KEY_W-1:0]    in_key,
	output logic                               found,
	output logic      [obts_pkg::KEY_W-1:0]    value,
	output logic      [obts_pkg::CNT_W-1:0]    element_count
);
	import obts_pkg::*;

	localparam logic [WORD_W-1:0] ONES = '1;

	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [WORD_W-1:0]  root_q;
	logic [CNT_W-1:0]   count_q;
	logic [LEAF_AW-1:0] clr_q;
	logic [DIG_W-1:0]   p2_q, p1_q;
	logic               res_found_q;
	logic [KEY_W-1:0]   res_value_q;

	logic [WORD_W-1:0]  lw, mw;
	logic               leaf_we, leaf_re, mid_we, mid_re;
	logic [LEAF_AW-1:0] leaf_waddr, leaf_raddr;
	logic [MID_AW-1:0]  mid_waddr, mid_raddr;
	logic [WORD_W-1:0]  leaf_wdata, mid_wdata;

	logic [DIG_W-1:0]   k2, k1, k0;
	logic               hit, lowest, wr;
	logic [WORD_W-1:0]  ml, mm, mr, lnew, mnew;
	act_t               act;
	logic [DIG_W-1:0]   p2_n, p1_n, dig_mid, dig_leaf;
	logic               found_n;
	logic [KEY_W-1:0]   value_n;

	obts_ram #(.WIDTH(WORD_W), .DEPTH(LEAF_DEPTH)) u_leaf (
		.clk(clk), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
		.re(leaf_re), .raddr(leaf_raddr), .rdata(lw)
	);

	obts_ram #(.WIDTH(WORD_W), .DEPTH(MID_DEPTH)) u_mid (
		.clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
		.re(mid_re), .raddr(mid_raddr), .rdata(mw)
	);

	always_comb begin
		k2 = key_q[3*DIG_W-1:2*DIG_W];
		k1 = key_q[2*DIG_W-1:DIG_W];
		k0 = key_q[DIG_W-1:0];
		hit    = lw[k0];
		lowest = (cmd_q == CMD_MIN) || (cmd_q == CMD_SUCC);
		// successor looks at >= in the leaf, > above; predecessor mirrors it
		if (lowest) begin
			ml = lw & (ONES << k0);
			mm = mw & ((ONES << k1) << 1);
			mr = root_q & ((ONES << k2) << 1);
		end else begin
			ml = lw & ~((ONES << k0) << 1);
			mm = mw & ~(ONES << k1);
			mr = root_q & ~(ONES << k2);
		end
		lnew = (cmd_q == CMD_INSERT) ? (lw | (WORD_W'(1) << k0))
		                             : (lw & ~(WORD_W'(1) << k0));
		mnew = (cmd_q == CMD_INSERT) ? (mw | (WORD_W'(1) << k1))
		     : ((lnew == '0) ? (mw & ~(WORD_W'(1) << k1)) : mw);
		dig_mid  = find_bit(mw, lowest);
		dig_leaf = find_bit(lw, lowest);

		act     = ACT_DONE;
		p2_n    = k2;
		p1_n    = k1;
		found_n = 1'b0;
		value_n = '0;
		wr      = 1'b0;
		unique case (cmd_q)
			CMD_INSERT: wr = !hit;
			CMD_ERASE:  wr = hit;
			CMD_MEMBER: found_n = hit;
			CMD_MIN, CMD_MAX: begin
				if (count_q != '0) begin
					act  = ACT_DMID;
					p2_n = find_bit(root_q, lowest);
				end
			end
			CMD_SUCC, CMD_PRED: begin
				if (ml != '0) begin
					found_n = 1'b1;
					value_n = {k2, k1, find_bit(ml, lowest)};
				end else if (mm != '0) begin
					act  = ACT_DLEAF;
					p1_n = find_bit(mm, lowest);
				end else if (mr != '0) begin
					act  = ACT_DMID;
					p2_n = find_bit(mr, lowest);
				end
			end
			default: ;
		endcase

		sts.act        = act;
		sts.clear_last = (clr_q == '1);

		leaf_we    = cmd.clear || (cmd.eval && wr);
		leaf_waddr = cmd.clear ? clr_q : key_q[KEY_W-1:DIG_W];
		leaf_wdata = cmd.clear ? '0 : lnew;
		mid_we     = leaf_we;
		mid_waddr  = cmd.clear ? clr_q[MID_AW-1:0] : k2;
		mid_wdata  = cmd.clear ? '0 : mnew;

		leaf_re = cmd.accept || (cmd.eval && act == ACT_DLEAF) || cmd.dmid;
		if (cmd.accept)    leaf_raddr = in_key[KEY_W-1:DIG_W];
		else if (cmd.dmid) leaf_raddr = {p2_q, dig_mid};
		else               leaf_raddr = {p2_n, p1_n};
		mid_re    = cmd.accept || (cmd.eval && act == ACT_DMID);
		mid_raddr = cmd.accept ? in_key[KEY_W-1:2*DIG_W] : p2_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.eval && wr) begin
				if (cmd_q == CMD_INSERT) begin
					root_q  <= root_q | (WORD_W'(1) << k2);
					count_q <= count_q + 1'b1;
				end else begin
					if (mnew == '0) root_q <= root_q & ~(WORD_W'(1) << k2);
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= in_command;
			key_q <= in_key;
		end
		if (cmd.eval) begin
			res_found_q <= found_n;
			res_value_q <= value_n;
			p2_q        <= p2_n;
			p1_q        <= p1_n;
		end
		if (cmd.dmid) p1_q <= dig_mid;
		if (cmd.dleaf) begin
			res_found_q <= 1'b1;
			res_value_q <= {p2_q, p1_q, dig_leaf};
		end
		if (cmd.push) begin
			found         <= res_found_q;
			value         <= res_value_q;
			element_count <= count_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ordered_bitmap_tree_set.sv
// ----------------------------------------------------------------------------
// ordered_bitmap_tree_set
// Ordered key set kept as a three-level tree of 64-bit occupancy words.
// ----------------------------------------------------------------------------
// Holds up to 2^18 keys: a root word in flops, 64 middle words and 4096
// leaf words in RAMs with registered reads. After reset the block runs a
// clearing pass over both RAMs with in_ready low. Each transaction then
// runs through its states before the next one can be accepted: insert,
// erase, member test and a successor/predecessor hit in the starting leaf
// go from evaluation to the done state; a hit in the middle word adds a
// leaf read; min, max and a hit at the root add a middle-word read, then a
// leaf read, as the registered RAM reads down the tree depend on each other.
// A finished result stalls in the last state for as long as the previous
// result still sits unaccepted in the output register. One transaction is
// in flight at a time; a finished result waits in the output register
// while the next transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_bitmap_tree_set (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [obts_pkg::CMD_W-1:0] command,
	input  wire logic [obts_pkg::KEY_W-1:0] key,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            found,
	output logic      [obts_pkg::KEY_W-1:0] value,
	output logic      [obts_pkg::CNT_W-1:0] element_count
);
	import obts_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	// sequencer: clear sweep, evaluate, descend, hand off
	obts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(ctl_sts), .cmd(ctl_cmd)
	);

	// word stores, root, count and search logic
	obts_dpath u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cmd(ctl_cmd), .sts(ctl_sts),
		.in_command(command), .in_key(key),
		.found(found), .value(value), .element_count(element_count)
	);

endmodule

`default_nettype wire

>>> rtl/obts_checker.sv
// ----------------------------------------------------------------------------
// obts_checker
// Port-level checks on the ordered bitmap tree set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module obts_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic [17:0] value,
	input wire logic [18:0] element_count
);

	`OBTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`OBTS_ASSERT_NOW(a_nofind_zero, clk, arst_n, out_valid && !found, value == 18'd0)
	`OBTS_ASSERT_NOW(a_count_range, clk, arst_n, out_valid, element_count <= 19'd262144)
	`OBTS_ASSERT_NXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind ordered_bitmap_tree_set obts_props u_obts_props (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.found(found), .value(value), .element_count(element_count)
);

`default_nettype wire

>>> verif/obts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obts_checker
// Watches both channels of the ordered bitmap tree set, keeps its own copy
// of the key set as a flat bitmap, predicts each result and compares.
// ----------------------------------------------------------------------------
module obts_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [obts_pkg::CMD_W-1:0] command,
	input  logic [obts_pkg::KEY_W-1:0] key,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       found,
	input  logic [obts_pkg::KEY_W-1:0] value,
	input  logic [obts_pkg::CNT_W-1:0] element_count,
	output int                         errors,
	output int                         pending,
	output int                         results_seen
);
	import obts_pkg::*;

	typedef struct packed {
		logic             found;
		logic [KEY_W-1:0] value;
		logic [CNT_W-1:0] count;
	} answer_t;

	localparam int KEYS = 1 << KEY_W;

	// flat bitmap view of the set; the tree is an encoding of the same thing
	logic [WORD_W-1:0] leaf_map [LEAF_DEPTH];
	logic [CNT_W-1:0]  key_total;
	answer_t           answers_due [$];

	assign pending = answers_due.size();

	function automatic logic has_key(int k);
		return leaf_map[k >> DIG_W][k % WORD_W];
	endfunction

	// scan whole words where possible; sets stay small so this is cheap
	function automatic int scan_up(int from);
		int w;
		w = from >> DIG_W;
		for (int b = from % WORD_W; b < WORD_W; b++)
			if (leaf_map[w][b]) return (w << DIG_W) + b;
		for (w = w + 1; w < LEAF_DEPTH; w++)
			if (leaf_map[w] != '0)
				for (int b = 0; b < WORD_W; b++)
					if (leaf_map[w][b]) return (w << DIG_W) + b;
		return -1;
	endfunction

	function automatic int scan_down(int from);
		int w;
		w = from >> DIG_W;
		for (int b = from % WORD_W; b >= 0; b--)
			if (leaf_map[w][b]) return (w << DIG_W) + b;
		for (w = w - 1; w >= 0; w--)
			if (leaf_map[w] != '0)
				for (int b = WORD_W - 1; b >= 0; b--)
					if (leaf_map[w][b]) return (w << DIG_W) + b;
		return -1;
	endfunction

	function automatic answer_t apply_command(logic [CMD_W-1:0] c, int k);
		answer_t a;
		int      hit;
		a   = '0;
		hit = -1;
		case (c)
			CMD_INSERT: if (!has_key(k)) begin
				leaf_map[k >> DIG_W][k % WORD_W] = 1'b1;
				key_total++;
			end
			CMD_ERASE: if (has_key(k)) begin
				leaf_map[k >> DIG_W][k % WORD_W] = 1'b0;
				key_total--;
			end
			CMD_MEMBER: a.found = has_key(k);
			CMD_MIN:    hit = scan_up(0);
			CMD_MAX:    hit = scan_down(KEYS - 1);
			CMD_SUCC:   hit = scan_up(k);
			CMD_PRED:   hit = scan_down(k);
			default: ;
		endcase
		if (hit >= 0) begin
			a.found = 1'b1;
			a.value = KEY_W'(hit);
		end
		a.count = key_total;
		return a;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors       = 0;
		results_seen = 0;
		key_total    = '0;
		foreach (leaf_map[i]) leaf_map[i] = '0;
	end

	always @(posedge clk) begin
		answer_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (answers_due.size() == 0) begin
					report("outstanding transactions", 0, 1);
				end else begin
					due = answers_due.pop_front();
					if (found !== due.found) report("found", found, due.found);
					if (value !== due.value) report("value", value, due.value);
					if (element_count !== due.count)
						report("element_count", element_count, due.count);
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(apply_command(command, int'(key)));
		end
	end

endmodule

>>> verif/tb_ordered_bitmap_tree_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_bitmap_tree_set
// Drives directed and then random bursts of command/key transactions into
// the tree set with a stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ordered_bitmap_tree_set;
	import obts_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [CMD_W-1:0] command;
	logic [KEY_W-1:0] key;
	logic             out_valid;
	logic             out_ready;
	logic             found;
	logic [KEY_W-1:0] value;
	logic [CNT_W-1:0] element_count;
	int               errors;
	int               pending;
	int               results_seen;
	int               sent;
	int               stall_mode;

	// Most keys fall in four small clusters so that inserts and erases
	// collide and searches cross word and middle-level boundaries.
	logic [KEY_W-1:0] cluster_base [4];

	ordered_bitmap_tree_set dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .key(key),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .value(value), .element_count(element_count)
	);

	obts_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .key(key),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .value(value), .element_count(element_count),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Send one transaction; valid stays up across back-to-back calls.
	task automatic send_transaction(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
		in_valid <= 1'b1;
		command  <= c;
		key      <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic idle_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return KEY_W'($urandom);
			1:       return $urandom_range(0, 1) ? '0 : '1;
			default: return cluster_base[$urandom_range(0, 3)] + KEY_W'($urandom_range(0, 200));
		endcase
	endfunction

	// Receiver: mode changes every so often between always ready,
	// random stalls and long stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode <= int'($urandom_range(0, 2));
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		logic [CMD_W-1:0] c;
		int               burst;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = '0;
		key      = '0;
		sent     = 0;
		cluster_base[0] = 18'h00000;
		cluster_base[1] = 18'h00fc0;
		cluster_base[2] = KEY_W'($urandom);
		cluster_base[3] = 18'h3ff30;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-set searches, extreme keys, duplicates, erase
		// of absent keys, boundaries between words and between middle words.
		send_transaction(CMD_MIN, '0);
		send_transaction(CMD_MAX, '1);
		send_transaction(CMD_SUCC, '0);
		send_transaction(CMD_PRED, '1);
		send_transaction(CMD_ERASE, 18'd5);
		send_transaction(CMD_INSERT, '0);
		send_transaction(CMD_INSERT, '1);
		send_transaction(CMD_INSERT, '1);
		send_transaction(CMD_INSERT, 18'd63);
		send_transaction(CMD_INSERT, 18'd4096);
		send_transaction(CMD_MEMBER, '1);
		send_transaction(CMD_MEMBER, 18'd1);
		send_transaction(CMD_MIN, '1);
		send_transaction(CMD_MAX, '0);
		send_transaction(CMD_SUCC, 18'd1);
		send_transaction(CMD_SUCC, 18'd64);
		send_transaction(CMD_PRED, 18'd4095);
		send_transaction(CMD_PRED, 18'd62);
		send_transaction(CMD_SUCC, 18'h2aaaa);
		send_transaction(CMD_ERASE, 18'd4096);
		send_transaction(CMD_SUCC, 18'd64);
		send_transaction(CMD_ERASE, '0);
		send_transaction(CMD_ERASE, 18'd63);
		send_transaction(CMD_PRED, 18'd4095);
		send_transaction(CMD_UNUSED, 18'h15555);

		// Random: insert-heavy early, then with erases mixed in so the set
		// grows and shrinks.
		while (sent < 800) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				case ($urandom_range(0, 9))
					0, 1, 2: c = CMD_INSERT;
					3, 4:    c = (sent < 400) ? CMD_INSERT : CMD_ERASE;
					5:       c = CMD_MEMBER;
					6:       c = $urandom_range(0, 1) ? CMD_MIN : CMD_MAX;
					7:       c = CMD_SUCC;
					8:       c = CMD_PRED;
					default: c = CMD_CMD_ANY();
				endcase
				send_transaction(c, pick_key());
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results over all seven commands.",
			sent, results_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// any code, including the unused one, so every command bit toggles
	function automatic logic [CMD_W-1:0] CMD_CMD_ANY();
		return CMD_W'($urandom_range(0, 7));
	endfunction

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
